@@ rtl/tile_edge_pixel_owner_shade_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the tile edge pixel owner shade core
// Concurrent checks used by the RTL; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef TILE_EDGE_PIXEL_OWNER_SHADE_CORE_DEFINES_SVH
`define TILE_EDGE_PIXEL_OWNER_SHADE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define TEPOS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tepos same-cycle check failed");
// Consequent must hold in the cycle after the antecedent
`define TEPOS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tepos next-cycle check failed");
`else
`define TEPOS_ASSERT_SAME(label, clk, rst, ante, cons)
`define TEPOS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/tepos_pkg.sv @@
// ----------------------------------------------------------------------------
// tepos_pkg
// Types, codes and constants shared by the tile edge pixel owner shade core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tepos_pkg;

   // Tile geometry; the tile size must be a power of two
   localparam int TILE_PIXELS = 32;
   localparam int PIX_W       = $clog2(TILE_PIXELS);
   localparam int HALF_TILE   = TILE_PIXELS / 2;
   localparam int EDGE_W      = 3;
   localparam int NUM_SLOTS   = 9;

   // Item actions
   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_RESOLVE = 1'b1;

   // Source classes
   localparam logic [1:0] CLS_NONE  = 2'd0;
   localparam logic [1:0] CLS_FLOOR = 2'd1;
   localparam logic [1:0] CLS_WALL  = 2'd2;
   localparam logic [1:0] CLS_BAD   = 2'd3;

   // Slots, neighbours clockwise from north, then the current cell
   localparam logic [3:0] SLOT_N   = 4'd0;
   localparam logic [3:0] SLOT_NE  = 4'd1;
   localparam logic [3:0] SLOT_E   = 4'd2;
   localparam logic [3:0] SLOT_SE  = 4'd3;
   localparam logic [3:0] SLOT_S   = 4'd4;
   localparam logic [3:0] SLOT_SW  = 4'd5;
   localparam logic [3:0] SLOT_W   = 4'd6;
   localparam logic [3:0] SLOT_NW  = 4'd7;
   localparam logic [3:0] SLOT_CUR = 4'd8;

   // Owner codes
   localparam logic [3:0] OWNER_KEEP = 4'd0;
   localparam logic [3:0] OWNER_MAX  = 4'd8;

   // Edge width hash multipliers
   localparam logic [31:0] HASH_A = 32'h9e3779b9;
   localparam logic [31:0] HASH_B = 32'h85ebca6b;
   localparam logic [31:0] HASH_C = 32'hc2b2ae35;

   // Shade levels
   localparam logic [7:0] SHADE_NONE      = 8'd255;
   localparam logic [7:0] SHADE_N_EDGE    = 8'd176;
   localparam logic [7:0] SHADE_N_INNER   = 8'd222;
   localparam logic [7:0] SHADE_S_EDGE    = 8'd226;
   localparam logic [7:0] SHADE_S_INNER   = 8'd246;
   localparam logic [7:0] SHADE_W_EDGE    = 8'd198;
   localparam logic [7:0] SHADE_W_INNER   = 8'd234;
   localparam logic [7:0] SHADE_E_EDGE    = 8'd218;
   localparam logic [7:0] SHADE_E_INNER   = 8'd242;
   localparam logic [7:0] SHADE_FACE_LOW  = 8'd180;
   localparam logic [7:0] SHADE_FACE_SIDE = 8'd218;
   localparam logic [7:0] SHADE_CORNER    = 8'd226;

   // Input item
   typedef struct packed {
      logic        action;
      logic [3:0]  slot;
      logic [1:0]  source_class;
      logic [15:0] source_priority;
      logic [63:0] source_material;
      logic [9:0]  cell_y;
      logic [9:0]  cell_x;
      logic [4:0]  pixel_x;
      logic [4:0]  pixel_y;
      logic        preserve_floor;
   } req_item_type;

   // Result item
   typedef struct packed {
      logic [3:0] owner;
      logic [7:0] shade;
   } rsp_item_type;

   // One source table entry
   typedef struct packed {
      logic [1:0]  cls;
      logic [15:0] prio;
      logic [63:0] material;
   } slot_entry_type;

   // Table entries seen by the quarter that holds the pixel
   typedef struct packed {
      slot_entry_type cur;
      slot_entry_type horz;
      slot_entry_type vert;
      slot_entry_type diag;
      logic [1:0]     south_cls;
      logic [1:0]     east_cls;
   } slot_view_type;

endpackage

@@ rtl/tepos_edge_width.sv @@
// ----------------------------------------------------------------------------
// tepos_edge_width
// Hashed blend edge width (2 or 3 pixels) along one tile edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tepos_edge_width (
   input  logic [9:0]                lead,
   input  logic [9:0]                trail,
   input  logic [tepos_pkg::PIX_W-1:0] along,
   output logic [1:0]                width
);
   import tepos_pkg::*;

   logic [PIX_W+6:0] third_prod;
   logic [PIX_W-1:0] third;
   logic [31:0]      mix;
   logic [31:0]      fold;
   logic [6:0]       nib_sum;
   logic [4:0]       nib_fold;
   logic             div5;
   logic             at_border;

   // along / 3 by reciprocal, exact below 128
   assign third_prod = (PIX_W+7)'(along) * (PIX_W+7)'(43);
   assign third      = PIX_W'(third_prod >> 7);

   // Coordinate hash, folded high half into low
   assign mix  = (32'(lead) * HASH_A) ^ (32'(trail) * HASH_B) ^ (32'(third) * HASH_C);
   assign fold = mix ^ (mix >> 16);

   // 16 = 1 mod 5, so summing nibbles keeps the residue
   assign nib_sum = 7'(fold[3:0])   + 7'(fold[7:4])   + 7'(fold[11:8])  + 7'(fold[15:12])
                  + 7'(fold[19:16]) + 7'(fold[23:20]) + 7'(fold[27:24]) + 7'(fold[31:28]);
   assign nib_fold = 5'(nib_sum[6:4]) + 5'(nib_sum[3:0]);

   always_comb begin
      div5 = nib_fold inside {5'd0, 5'd5, 5'd10, 5'd15, 5'd20};
   end

   // Corners of the edge always get the full width
   assign at_border = (along < PIX_W'(EDGE_W)) || (along >= PIX_W'(TILE_PIXELS - EDGE_W));

   assign width = (at_border || !div5) ? 2'(EDGE_W) : 2'(EDGE_W - 1);

endmodule

@@ rtl/tepos_slot_table.sv @@
// ----------------------------------------------------------------------------
// tepos_slot_table
// Nine-slot source table with quarter selection of the neighbours.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tepos_slot_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [3:0]                wr_slot,
   input  tepos_pkg::slot_entry_type wr_entry,
   input  logic                      left,
   input  logic                      top,
   output tepos_pkg::slot_view_type  view
);
   import tepos_pkg::*;

   slot_entry_type slot_ff [NUM_SLOTS];

   // Slot write; out-of-range slots are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_ff[i] <= '0;
         end
      end else if (wr_en && wr_slot <= SLOT_CUR) begin
         slot_ff[wr_slot] <= wr_entry;
      end
   end

   // Neighbours of the quarter that holds the pixel
   always_comb begin
      view.cur       = slot_ff[SLOT_CUR];
      view.horz      = left ? slot_ff[SLOT_W] : slot_ff[SLOT_E];
      view.vert      = top  ? slot_ff[SLOT_N] : slot_ff[SLOT_S];
      if (left) begin
         view.diag = top ? slot_ff[SLOT_NW] : slot_ff[SLOT_SW];
      end else begin
         view.diag = top ? slot_ff[SLOT_NE] : slot_ff[SLOT_SE];
      end
      view.south_cls = slot_ff[SLOT_S].cls;
      view.east_cls  = slot_ff[SLOT_E].cls;
   end

endmodule

@@ rtl/tepos_resolve.sv @@
// ----------------------------------------------------------------------------
// tepos_resolve
// Owner and depth shade of one pixel from the selected table entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tepos_resolve (
   input  logic [9:0]                  cell_y,
   input  logic [9:0]                  cell_x,
   input  logic [tepos_pkg::PIX_W-1:0] px,
   input  logic [tepos_pkg::PIX_W-1:0] py,
   input  logic                        left,
   input  logic                        top,
   input  logic                        preserve_floor,
   input  tepos_pkg::slot_view_type    view,
   output tepos_pkg::rsp_item_type     result
);
   import tepos_pkg::*;

   // Donor has the base's class, differs in material and ranks higher
   function automatic logic ranks_above(input slot_entry_type base,
                                        input slot_entry_type donor);
      logic differ;
      differ = base.cls != CLS_NONE && donor.cls != CLS_NONE
            && (base.cls != donor.cls || base.material != donor.material);
      return donor.cls == base.cls && differ
          && (donor.prio > base.prio
              || (donor.prio == base.prio && donor.material > base.material));
   endfunction

   function automatic logic [7:0] min_shade(input logic [7:0] a, input logic [7:0] b);
      return (a < b) ? a : b;
   endfunction

   logic [3:0]       hn, vn, dn;
   logic [PIX_W-1:0] u, w;
   logic [PIX_W:0]   uw_sum;
   logic [1:0]       ew_v, ew_h;
   logic [1:0]       cur_cls, other_cls;
   logic             cut_h, cut_v, own_h, own_v, own_d, may_give;
   logic             corner_ok;
   logic [7:0]       shade_a, shade_b, shade_ab;
   logic [3:0]       owner_sel;
   logic [7:0]       shade_sel;

   // Quarter neighbours and distances from the nearest edges
   assign hn = left ? SLOT_W : SLOT_E;
   assign vn = top  ? SLOT_N : SLOT_S;
   assign dn = left ? (top ? SLOT_NW : SLOT_SW) : (top ? SLOT_NE : SLOT_SE);
   assign u  = left ? px : PIX_W'(TILE_PIXELS - 1) - px;
   assign w  = top  ? py : PIX_W'(TILE_PIXELS - 1) - py;
   assign uw_sum = (PIX_W+1)'(u) + (PIX_W+1)'(w);

   // Width of the west/east cut varies along y, north/south cut along x
   tepos_edge_width u_width_v (
      .lead  (cell_y),
      .trail (cell_x),
      .along (py),
      .width (ew_v)
   );

   tepos_edge_width u_width_h (
      .lead  (cell_x),
      .trail (cell_y),
      .along (px),
      .width (ew_h)
   );

   assign cur_cls = view.cur.cls;

   // Owner: cardinal cuts, then the concave notch
   assign may_give  = !(preserve_floor && cur_cls == CLS_FLOOR);
   assign cut_h     = ranks_above(view.cur, view.horz);
   assign cut_v     = ranks_above(view.cur, view.vert);
   assign corner_ok = view.horz.cls == cur_cls && view.vert.cls == cur_cls;
   assign own_h     = cut_h && u < PIX_W'(ew_v);
   assign own_v     = cut_v && w < PIX_W'(ew_h)
                   && (!own_h || w < u || (w == u && ranks_above(view.horz, view.vert)));
   assign own_d     = !cut_h && !cut_v && ranks_above(view.cur, view.diag) && corner_ok
                   && uw_sum < (PIX_W+1)'(EDGE_W);

   always_comb begin
      owner_sel = OWNER_KEEP;
      if (may_give) begin
         if (own_d) begin
            owner_sel = dn + 4'd1;
         end else if (own_v) begin
            owner_sel = vn + 4'd1;
         end else if (own_h) begin
            owner_sel = hn + 4'd1;
         end
      end
   end

   // Shade: contact shadow on floor, face shade on other cells
   assign other_cls = (cur_cls == CLS_FLOOR) ? CLS_WALL : CLS_FLOOR;

   always_comb begin
      shade_a = SHADE_NONE;
      shade_b = SHADE_NONE;
      if (cur_cls == CLS_FLOOR) begin
         if (view.vert.cls == other_cls && w < PIX_W'(2)) begin
            if (top) begin
               shade_a = (w == '0) ? SHADE_N_EDGE : SHADE_N_INNER;
            end else begin
               shade_a = (w == '0) ? SHADE_S_EDGE : SHADE_S_INNER;
            end
         end
         if (view.horz.cls == other_cls && u < PIX_W'(2)) begin
            if (left) begin
               shade_b = (u == '0) ? SHADE_W_EDGE : SHADE_W_INNER;
            end else begin
               shade_b = (u == '0) ? SHADE_E_EDGE : SHADE_E_INNER;
            end
         end
      end else begin
         if (view.south_cls == other_cls && py >= PIX_W'(TILE_PIXELS - 2)) begin
            shade_a = (py == PIX_W'(TILE_PIXELS - 1)) ? SHADE_FACE_LOW : SHADE_FACE_SIDE;
         end
         if (view.east_cls == other_cls && px == PIX_W'(TILE_PIXELS - 1)) begin
            shade_b = SHADE_FACE_SIDE;
         end
      end
      shade_ab = min_shade(shade_a, shade_b);
      // Inner corner touch
      if (view.diag.cls == other_cls && uw_sum < (PIX_W+1)'(2) && corner_ok) begin
         shade_sel = min_shade(shade_ab, SHADE_CORNER);
      end else begin
         shade_sel = shade_ab;
      end
   end

   assign result = '{owner: owner_sel, shade: shade_sel};

endmodule

@@ rtl/tile_edge_pixel_owner_shade_core.sv @@
// ----------------------------------------------------------------------------
// tile_edge_pixel_owner_shade_core
// Per-pixel owner and depth shade resolver for tile boundary blending.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: an item either loads one source slot (action load) or
//   resolves one pixel (action resolve). Loads give no result; each resolve
//   gives exactly one rsp item with the owning neighbour and a shade byte.
//   Items are taken at a clock edge with req_valid high and req_stall low.
//   A resolve item is held in the input register, then its result is
//   registered in the result register that drives rsp. Throughput: one
//   item per cycle while req_stall is low, loads and resolves in any mix;
//   a load takes effect for a resolve accepted in the very next cycle.
//   The rate is set by the input register and result register pair; all
//   owner and shade logic sits between them.
//   Reset (synchronous) clears the source table to class none and empties
//   both registers. When rsp_stall holds a result, a resolve waiting in the
//   input register raises req_stall; loads still drain past it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tile_edge_pixel_owner_shade_core_defines.svh"

module tile_edge_pixel_owner_shade_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  tepos_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output tepos_pkg::rsp_item_type rsp_item
);
   import tepos_pkg::*;

   logic           s1_valid_ff, s1_valid_in;
   req_item_type   s1_item_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_item_type   rsp_item_ff;
   rsp_item_type   result;
   slot_view_type  view;
   slot_entry_type wr_entry;
   logic           accept, out_busy, s1_resolve, s1_advance, s1_load;
   logic [PIX_W-1:0] px, py;
   logic           left, top;

   // Handshake control
   assign s1_resolve = s1_valid_ff && s1_item_ff.action == ACT_RESOLVE;
   assign s1_load    = s1_valid_ff && s1_item_ff.action == ACT_LOAD;
   assign out_busy   = rsp_valid_ff && rsp_stall;
   assign req_stall  = s1_resolve && out_busy;
   assign accept     = req_valid && !req_stall;
   assign s1_advance = s1_valid_ff && !req_stall;

   // Input register
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
   end

   // Slot load; class code three is stored as none
   assign wr_entry = '{cls: (s1_item_ff.source_class == CLS_BAD) ? CLS_NONE
                                                               : s1_item_ff.source_class,
                       prio: s1_item_ff.source_priority,
                       material: s1_item_ff.source_material};

   // Pixel within the tile and its quarter
   assign px   = PIX_W'(s1_item_ff.pixel_x);
   assign py   = PIX_W'(s1_item_ff.pixel_y);
   assign left = px < PIX_W'(HALF_TILE);
   assign top  = py < PIX_W'(HALF_TILE);

   tepos_slot_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (s1_load),
      .wr_slot  (s1_item_ff.slot),
      .wr_entry (wr_entry),
      .left     (left),
      .top      (top),
      .view     (view)
   );

   tepos_resolve u_resolve (
      .cell_y         (s1_item_ff.cell_y),
      .cell_x         (s1_item_ff.cell_x),
      .px             (px),
      .py             (py),
      .left           (left),
      .top            (top),
      .preserve_floor (s1_item_ff.preserve_floor),
      .view           (view),
      .result         (result)
   );

   // Result register
   always_comb begin
      if (s1_resolve && s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_resolve && s1_advance) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Checks
   `TEPOS_ASSERT_SAME(a_stall_only_resolve, clock, reset, req_stall, s1_resolve && rsp_valid_ff)
   `TEPOS_ASSERT_SAME(a_blocked_resolve_stalls, clock, reset, s1_resolve && out_busy, req_stall)
   `TEPOS_ASSERT_NEXT(a_resolve_gives_result, clock, reset, s1_resolve && !out_busy, rsp_valid)
   `TEPOS_ASSERT_SAME(a_owner_range, clock, reset, rsp_valid_ff, rsp_item_ff.owner <= OWNER_MAX)

endmodule
